// File: src/page_translation_window_lru_macros.svh
// ---------------------------------------------------------------------------
// page_translation_window_lru_macros
// assertion macros used by the translator top level
// ---------------------------------------------------------------------------
`ifndef PAGE_TRANSLATION_WINDOW_LRU_MACROS_SVH
`define PAGE_TRANSLATION_WINDOW_LRU_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTW_ASSERT_NOW(label, ante, cons, msg)
`define PTW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: src/ptw_pkg.sv
// ---------------------------------------------------------------------------
// ptw_pkg
// types and constants of the page translation block
// ---------------------------------------------------------------------------
package ptw_pkg;

  localparam int ADDR_W          = 32;
  localparam int PAGE_ENTRIES    = 1024;
  localparam int PAGE_W          = 10;
  localparam int FRAME_ENTRIES_D = 64;
  localparam int WINDOW_LEN_D    = 16;
  localparam int HIT_W           = 5;
  localparam logic [HIT_W-1:0] HIT_MAX = 5'd31;
  localparam int TDATA_W         = 80;
  localparam int TUSER_W         = 3;

  localparam logic [4:0]  OFFSET_W_RST = 5'd12;
  localparam logic [6:0]  FRAME_CNT_RST = 7'd64;
  localparam logic [10:0] PAGE_CNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    CFG_OFFSET_WIDTH = 2'd0,
    CFG_FRAME_COUNT  = 2'd1,
    CFG_PAGE_COUNT   = 2'd2
  } ptw_cfg_idx_t;

  typedef struct packed {
    logic [4:0]  offset_width;
    logic [6:0]  frame_count;
    logic [10:0] page_count;
  } ptw_cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_SCAN, ST_OWNER, ST_UNMAP,
    ST_FAULT_WR, ST_LV_RD, ST_LV_WR, ST_INC_RD, ST_INC_WR, ST_DONE
  } ptw_state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic map_rd;
    logic decide;
    logic scan_start;
    logic scan_step;
    logic owner_rd;
    logic unmap;
    logic fault_wr;
    logic lv_rd;
    logic lv_wr;
    logic inc_rd;
    logic inc_wr;
    logic out_load;
  } ptw_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic bad;
    logic mapped;
    logic free_avail;
    logic scan_done;
    logic window_full;
    logic out_free;
  } ptw_status_t;

endpackage

// File: src/ptw_ctrl.sv
// ---------------------------------------------------------------------------
// ptw_ctrl
// sequencer for lookup, fault handling, victim scan and window update
// ---------------------------------------------------------------------------
module ptw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ptw_pkg::ptw_status_t sts,
  output ptw_pkg::ptw_cmd_t    cmd
);

  ptw_pkg::ptw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptw_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ptw_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = ptw_pkg::ST_IDLE;
      end
      ptw_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = ptw_pkg::ST_READ;
      end
      ptw_pkg::ST_READ: begin
        cmd.map_rd = 1'b1;
        state_nxt  = ptw_pkg::ST_DECIDE;
      end
      ptw_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.bad) begin
          state_nxt = ptw_pkg::ST_DONE;
        end else if (sts.mapped) begin
          state_nxt = sts.window_full ? ptw_pkg::ST_LV_RD : ptw_pkg::ST_INC_RD;
        end else if (sts.free_avail) begin
          state_nxt = ptw_pkg::ST_FAULT_WR;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ptw_pkg::ST_SCAN;
        end
      end
      ptw_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = ptw_pkg::ST_OWNER;
      end
      ptw_pkg::ST_OWNER: begin
        cmd.owner_rd = 1'b1;
        state_nxt    = ptw_pkg::ST_UNMAP;
      end
      ptw_pkg::ST_UNMAP: begin
        cmd.unmap = 1'b1;
        state_nxt = ptw_pkg::ST_FAULT_WR;
      end
      ptw_pkg::ST_FAULT_WR: begin
        cmd.fault_wr = 1'b1;
        state_nxt = sts.window_full ? ptw_pkg::ST_LV_RD : ptw_pkg::ST_INC_RD;
      end
      ptw_pkg::ST_LV_RD: begin
        cmd.lv_rd = 1'b1;
        state_nxt = ptw_pkg::ST_LV_WR;
      end
      ptw_pkg::ST_LV_WR: begin
        cmd.lv_wr = 1'b1;
        state_nxt = ptw_pkg::ST_INC_RD;
      end
      ptw_pkg::ST_INC_RD: begin
        cmd.inc_rd = 1'b1;
        state_nxt  = ptw_pkg::ST_INC_WR;
      end
      ptw_pkg::ST_INC_WR: begin
        cmd.inc_wr = 1'b1;
        state_nxt  = ptw_pkg::ST_DONE;
      end
      ptw_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ptw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptw_pkg::ST_CLEAR;
    endcase
  end

endmodule

// File: src/ptw_dp.sv
// ---------------------------------------------------------------------------
// ptw_dp
// page table, frame tables, hit counts, access window and result register
// ---------------------------------------------------------------------------
module ptw_dp #(
  parameter int FRAME_ENTRIES = ptw_pkg::FRAME_ENTRIES_D,
  parameter int WINDOW_LEN    = ptw_pkg::WINDOW_LEN_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptw_pkg::ptw_cfg_t             cfg,
  input  ptw_pkg::ptw_cmd_t             cmd,
  output ptw_pkg::ptw_status_t          sts,
  input  logic [ptw_pkg::ADDR_W-1:0]    in_va,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ptw_pkg::TDATA_W-1:0]   out_tdata,
  output logic [ptw_pkg::TUSER_W-1:0]   out_tuser
);

  localparam int FW  = $clog2(FRAME_ENTRIES);
  localparam int FCW = $clog2(FRAME_ENTRIES + 1);
  localparam int SW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int RW  = $clog2(WINDOW_LEN + 1);
  localparam int PW  = ptw_pkg::PAGE_W;
  localparam int HW  = ptw_pkg::HIT_W;
  localparam int AW  = ptw_pkg::ADDR_W;

  // clamped configuration
  logic [4:0]    ow;
  logic [FCW-1:0] nframes;
  logic [10:0]   npages;

  always_comb begin
    if (cfg.offset_width < 5'd4)       ow = 5'd4;
    else if (cfg.offset_width > 5'd16) ow = 5'd16;
    else                               ow = cfg.offset_width;
    if (cfg.frame_count < 7'd2)                  nframes = FCW'(2);
    else if (int'(cfg.frame_count) > FRAME_ENTRIES) nframes = FCW'(FRAME_ENTRIES);
    else                                         nframes = FCW'(cfg.frame_count);
    if (cfg.page_count < 11'd1)                  npages = 11'd1;
    else if (cfg.page_count > 11'd1024)          npages = 11'd1024;
    else                                         npages = cfg.page_count;
  end

  // item registers
  logic [PW-1:0]  page_r;
  logic [15:0]    offset_r;
  logic           bad_r;
  logic [FW-1:0]  frame_r;
  logic           fault_r, evicted_r;
  logic [PW-1:0]  ev_page_r;
  logic [31:0]    fault_cnt_r;
  logic [FCW-1:0] next_free_r;

  logic [AW-1:0]  page_full;
  logic [15:0]    off_mask;
  assign page_full = in_va >> ow;
  assign off_mask  = 16'((17'd1 << ow) - 17'd1);

  // page table: valid bit and frame per entry
  logic [FW:0]    map_mem [ptw_pkg::PAGE_ENTRIES];
  logic [FW:0]    map_q_r;
  logic [PW-1:0]  clr_idx_r;
  logic           map_we;
  logic [PW-1:0]  map_wa;
  logic [FW:0]    map_wd;

  // frame owner table
  logic [PW-1:0]  owner_mem [FRAME_ENTRIES];
  logic [PW-1:0]  owner_q_r;

  // hit counts with per-frame valid bits
  logic [HW-1:0]  hit_mem [FRAME_ENTRIES];
  logic [FRAME_ENTRIES-1:0] hvalid_r;
  logic [HW-1:0]  hq_r;
  logic           hq_v_r;
  logic [FW-1:0]  hq_idx_r;
  logic [HW-1:0]  hcnt;
  logic           hit_re, hit_we;
  logic [FW-1:0]  hit_ra, hit_wa;
  logic [HW-1:0]  hit_wd;

  // access window
  logic [FW-1:0]  recent_r [WINDOW_LEN];
  logic [SW-1:0]  slot_r;
  logic [RW-1:0]  filled_r;

  // victim scan
  logic [FCW-1:0] scan_idx_r;
  logic           scan_pend_r;
  logic [FW-1:0]  best_r;
  logic [HW-1:0]  best_cnt_r;

  assign hcnt = hq_v_r ? hq_r : '0;

  always_comb begin
    map_we = 1'b0;
    map_wa = page_r;
    map_wd = '0;
    if (cmd.clr_wr) begin
      map_we = 1'b1;
      map_wa = clr_idx_r;
    end else if (cmd.unmap) begin
      map_we = 1'b1;
      map_wa = owner_q_r;
    end else if (cmd.fault_wr) begin
      map_we = 1'b1;
      map_wd = {1'b1, frame_r};
    end
  end

  always_comb begin
    hit_re = 1'b0;
    hit_ra = frame_r;
    if (cmd.scan_step && (scan_idx_r < nframes)) begin
      hit_re = 1'b1;
      hit_ra = scan_idx_r[FW-1:0];
    end else if (cmd.lv_rd) begin
      hit_re = 1'b1;
      hit_ra = recent_r[slot_r];
    end else if (cmd.inc_rd) begin
      hit_re = 1'b1;
    end
    hit_we = 1'b0;
    hit_wa = hq_idx_r;
    hit_wd = '0;
    if (cmd.fault_wr) begin
      hit_we = 1'b1;
      hit_wa = frame_r;
    end else if (cmd.lv_wr) begin
      hit_we = 1'b1;
      hit_wd = (hcnt != '0) ? hcnt - HW'(1) : '0;
    end else if (cmd.inc_wr) begin
      hit_we = 1'b1;
      hit_wd = (hcnt < ptw_pkg::HIT_MAX) ? hcnt + HW'(1) : hcnt;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd.map_rd) map_q_r <= map_mem[page_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.fault_wr) owner_mem[frame_r] <= page_r;
    if (cmd.owner_rd) owner_q_r <= owner_mem[best_r];
  end

  always_ff @(posedge clk) begin
    if (hit_we) hit_mem[hit_wa] <= hit_wd;
    if (hit_re) hq_r <= hit_mem[hit_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
    end else if (hit_we) begin
      hvalid_r[hit_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_re) begin
      hq_v_r   <= hvalid_r[hit_ra];
      hq_idx_r <= hit_ra;
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      fault_cnt_r <= '0;
      next_free_r <= FCW'(1);
      slot_r      <= '0;
      filled_r    <= '0;
      scan_pend_r <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      if (cmd.clr_wr) clr_idx_r <= clr_idx_r + PW'(1);
      if (cmd.decide && !bad_r && !map_q_r[FW]) begin
        if (fault_cnt_r != 32'hFFFF_FFFF) fault_cnt_r <= fault_cnt_r + 32'd1;
        if (next_free_r < nframes) next_free_r <= next_free_r + FCW'(1);
      end
      if (cmd.scan_start) begin
        scan_idx_r  <= FCW'(1);
        scan_pend_r <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_pend_r <= (scan_idx_r < nframes);
        if (scan_idx_r < nframes) scan_idx_r <= scan_idx_r + FCW'(1);
      end
      if (cmd.inc_wr) begin
        slot_r <= (int'(slot_r) == WINDOW_LEN - 1) ? '0 : slot_r + SW'(1);
        if (int'(filled_r) < WINDOW_LEN) filled_r <= filled_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.inc_wr) recent_r[slot_r] <= frame_r;
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r    <= page_full[PW-1:0];
      offset_r  <= in_va[15:0] & off_mask;
      bad_r     <= page_full >= {21'd0, npages};
      fault_r   <= 1'b0;
      evicted_r <= 1'b0;
      ev_page_r <= '0;
    end
    if (cmd.decide && !bad_r) begin
      if (map_q_r[FW]) begin
        frame_r <= map_q_r[FW-1:0];
      end else begin
        fault_r <= 1'b1;
        frame_r <= next_free_r[FW-1:0];
      end
    end
    if (scan_pend_r && cmd.scan_step) begin
      if (hq_idx_r == FW'(1) || hcnt < best_cnt_r) begin
        best_r     <= hq_idx_r;
        best_cnt_r <= hcnt;
      end
    end
    if (cmd.owner_rd) frame_r <= best_r;
    if (cmd.unmap) begin
      evicted_r <= 1'b1;
      ev_page_r <= owner_q_r;
    end
  end

  // result register
  logic [AW-1:0] phys;
  assign phys = bad_r ? '0 :
                ((AW'(frame_r) << ow) | AW'(offset_r));

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= {6'd0, fault_cnt_r, ev_page_r, phys};
      out_tuser <= {bad_r, evicted_r, fault_r};
    end
  end

  assign out_tvalid = out_valid_r;

  assign sts.clr_done    = (clr_idx_r == PW'(ptw_pkg::PAGE_ENTRIES - 1));
  assign sts.bad         = bad_r;
  assign sts.mapped      = map_q_r[FW];
  assign sts.free_avail  = next_free_r < nframes;
  assign sts.scan_done   = (scan_idx_r == nframes) && !scan_pend_r;
  assign sts.window_full = int'(filled_r) >= WINDOW_LEN;
  assign sts.out_free    = !out_valid_r || out_tready;

endmodule

// File: src/page_translation_window_lru.sv
// ---------------------------------------------------------------------------
// page_translation_window_lru
// demand-paging address translator, windowed least-hit frame replacement
//
//   channel  dir  ports                         items
//   in_      in   tvalid tready tdata[31:0]      virtual address
//   out_     out  tvalid tready tdata tuser      translation result
//   cfg_     in   valid ready index data         register write
//
// a hit or a fault with a free frame goes through read, decide, a fault
// write if needed, the window update and the hit-count increment; a fault
// with no free frame adds a hit-count scan, one frame per cycle through
// the hit-count memory; after reset no item is taken until the page table
// is cleared; one item is in flight at a time; a waiting result does not
// block the next accept, only the load of the next result
// ---------------------------------------------------------------------------
`include "page_translation_window_lru_macros.svh"

module page_translation_window_lru #(
  parameter int FRAME_ENTRIES = ptw_pkg::FRAME_ENTRIES_D,
  parameter int WINDOW_LEN    = ptw_pkg::WINDOW_LEN_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // virtual_address[31:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ptw_pkg::ADDR_W-1:0]  in_tdata,
  // physical_address[31:0], evicted_page[41:32], fault_total[73:42], zero pad
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ptw_pkg::TDATA_W-1:0] out_tdata,
  // page_fault[0], evicted[1], bad_page[2]
  output logic [ptw_pkg::TUSER_W-1:0] out_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [10:0]                 cfg_data
);

  // configuration registers; the user must write them only while idle, the block does not enforce it
  ptw_pkg::ptw_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_width <= ptw_pkg::OFFSET_W_RST;
      cfg_r.frame_count  <= ptw_pkg::FRAME_CNT_RST;
      cfg_r.page_count   <= ptw_pkg::PAGE_CNT_RST;
    end else if (cfg_valid) begin
      unique case (ptw_pkg::ptw_cfg_idx_t'(cfg_index))
        ptw_pkg::CFG_OFFSET_WIDTH: cfg_r.offset_width <= cfg_data[4:0];
        ptw_pkg::CFG_FRAME_COUNT:  cfg_r.frame_count  <= cfg_data[6:0];
        ptw_pkg::CFG_PAGE_COUNT:   cfg_r.page_count   <= cfg_data;
        default: ; // unused index, ignored
      endcase
    end
  end

  ptw_pkg::ptw_cmd_t    cmd;
  ptw_pkg::ptw_status_t sts;

  // sequencer
  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables and result register
  ptw_dp #(
    .FRAME_ENTRIES (FRAME_ENTRIES),
    .WINDOW_LEN    (WINDOW_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .in_va      (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // one item in flight: no accept right after an accept
  `PTW_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accept while busy")
  // an eviction only happens on a fault
  `PTW_ASSERT_NOW(a_evict_is_fault, out_tvalid && out_tuser[1], out_tuser[0], "evict w/o fault")
  // a bad page gives no translation and no fault
  `PTW_ASSERT_NOW(a_bad_page_clean, out_tvalid && out_tuser[2],
    out_tdata[31:0] == 32'd0 && out_tuser[1:0] == 2'b00, "bad page result not clean")

endmodule
